>>> rtl/rgb565_nearest_downscale_gray_assert.svh
// Assertion macros used by the downscaler top level.
`ifndef RGB565_NEAREST_DOWNSCALE_GRAY_ASSERT_SVH
`define RGB565_NEAREST_DOWNSCALE_GRAY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RNGD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rngd assertion failed");

// Next-cycle implication, checked outside reset.
`define RNGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rngd assertion failed");

`endif

>>> rtl/rngd_pkg.sv
// Types, constants and sizing for the RGB565 nearest-neighbor gray downscaler.
package rngd_pkg;

    localparam int OUT_WIDTH      = 320;
    localparam int OUT_HEIGHT     = 240;
    localparam int MAX_SOURCE_DIM = 2048;

    localparam int SRC_W_RESET = 320;
    localparam int SRC_H_RESET = 240;

    localparam int DIM_W   = $clog2(MAX_SOURCE_DIM + 1);
    localparam int SRC_W   = $clog2(MAX_SOURCE_DIM);
    localparam int CQ_W    = $clog2(MAX_SOURCE_DIM / OUT_WIDTH + 1);
    localparam int RQ_W    = $clog2(MAX_SOURCE_DIM / OUT_HEIGHT + 1);
    localparam int COL_RW  = $clog2(OUT_WIDTH);
    localparam int ROW_RW  = $clog2(OUT_HEIGHT);
    localparam int NCOL_W  = $clog2(OUT_WIDTH + 1);
    localparam int NROW_W  = $clog2(OUT_HEIGHT + 1);
    localparam int OCOL_W  = $clog2(OUT_WIDTH);
    localparam int OROW_W  = $clog2(OUT_HEIGHT);

    localparam int GRAY_R = 77;
    localparam int GRAY_G = 150;
    localparam int GRAY_B = 29;

    typedef enum logic [0:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic        frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]        gray_value;
        logic [OCOL_W-1:0] out_column;
        logic [OROW_W-1:0] out_row;
        logic              frame_done;
    } t_gray_out;

    // Effective size and its quotient/remainder against the output size.
    typedef struct packed {
        logic [DIM_W-1:0]  size;
        logic [CQ_W-1:0]   quot;
        logic [COL_RW-1:0] rem;
    } t_col_step;

    typedef struct packed {
        logic [DIM_W-1:0]  size;
        logic [RQ_W-1:0]   quot;
        logic [ROW_RW-1:0] rem;
    } t_row_step;

    typedef struct packed {
        t_col_step col;
        t_row_step row;
    } t_scale;

    typedef struct packed {
        logic              hit;
        logic [OCOL_W-1:0] column;
        logic [OROW_W-1:0] row;
        logic              last;
    } t_pos;

endpackage

>>> rtl/rgb565_nearest_downscale_gray.sv
// Top level of the RGB565 nearest-neighbor downscaler with gray output.
//
// Source pixels enter on the i_pix channel (valid/ready) in raster order;
// frame_start marks pixel (0,0). Each transfer lands in an input register,
// one pass of logic decides whether it is the nearest-neighbor sample for
// the next output position and forms its luma, and the gray byte with its
// output column/row goes to a result register on the o_gray channel.
// Pixels that are not sample points produce no result transfer.
// A sampled pixel goes through the input register and then the result
// register to o_gray. Throughput: one source pixel per cycle while o_gray is
// not stalled, set by the single pass from the input to the result register.
// When o_gray stalls, the result register holds and the input register keeps
// one more pixel; o_pix_ready drops only when both are full and the receiver
// is not ready.
// The user must write source width/height via the i_cfg_* port while idle;
// the block does not enforce it. Clamping keeps them between the output size
// and MAX_SOURCE_DIM. Reset loads 320x240 and clears all counters and valids.
`include "rgb565_nearest_downscale_gray_assert.svh"

module rgb565_nearest_downscale_gray (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  rngd_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [11:0]         i_cfg_data,
    input  logic                i_pix_valid,
    output logic                o_pix_ready,
    input  rngd_pkg::t_pix_in   i_pix,
    output logic                o_gray_valid,
    input  logic                i_gray_ready,
    output rngd_pkg::t_gray_out o_gray
);
    import rngd_pkg::*;

    logic      r_in_valid;
    t_pix_in   r_in;
    logic      r_out_valid;
    t_gray_out r_out;

    t_scale    w_scale;
    t_pos      w_pos;
    logic [7:0] w_gray;
    logic      w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || i_gray_ready);
    assign o_pix_ready = !r_in_valid || w_adv;

    rngd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_scale    (w_scale)
    );

    rngd_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_frame_start (r_in.frame_start),
        .i_scale       (w_scale),
        .o_pos         (w_pos)
    );

    rngd_gray u_gray (
        .i_pixel (r_in.pixel_rgb565),
        .o_gray  (w_gray)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_pix_ready) begin
            r_in_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pix_ready && i_pix_valid) begin
            r_in <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_pos.hit;
        end else if (i_gray_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pos.hit) begin
            r_out.gray_value <= w_gray;
            r_out.out_column <= w_pos.column;
            r_out.out_row    <= w_pos.row;
            r_out.frame_done <= w_pos.last;
        end
    end

    assign o_gray_valid = r_out_valid;
    assign o_gray       = r_out;

    `RNGD_ASSERT_IMPLY(a_done_at_corner, i_clk, i_rst_n, o_gray_valid && o_gray.frame_done, (o_gray.out_column == OCOL_W'(OUT_WIDTH - 1)) && (o_gray.out_row == OROW_W'(OUT_HEIGHT - 1)))
    `RNGD_ASSERT_IMPLY(a_pos_in_range, i_clk, i_rst_n, o_gray_valid, (o_gray.out_column < OCOL_W'(OUT_WIDTH - 1) || o_gray.out_column == OCOL_W'(OUT_WIDTH - 1)) && (o_gray.out_row < OROW_W'(OUT_HEIGHT - 1) || o_gray.out_row == OROW_W'(OUT_HEIGHT - 1)))
    `RNGD_ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n, !o_pix_ready, r_in_valid && r_out_valid && !i_gray_ready)
    `RNGD_ASSERT_NEXT(a_held_pixel_kept, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in))

endmodule

>>> rtl/rngd_cfg.sv
// Size registers with clamping and precomputed sample-step quotient and remainder.
module rngd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  rngd_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [11:0]         i_cfg_data,
    output rngd_pkg::t_scale    o_scale
);
    import rngd_pkg::*;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [11:0] v, input int lo);
        logic [DIM_W-1:0] x;
        x = DIM_W'(v);
        if (x < DIM_W'(lo)) begin
            return DIM_W'(lo);
        end
        if (x > DIM_W'(MAX_SOURCE_DIM)) begin
            return DIM_W'(MAX_SOURCE_DIM);
        end
        return x;
    endfunction

    function automatic t_col_step make_col(input logic [11:0] v);
        t_col_step s;
        logic [DIM_W-1:0] prod;
        s.size = clamp_dim(v, OUT_WIDTH);
        s.quot = '0;
        for (int k = 1; k <= MAX_SOURCE_DIM / OUT_WIDTH; k++) begin
            if (s.size >= DIM_W'(k * OUT_WIDTH)) begin
                s.quot = CQ_W'(k);
            end
        end
        prod  = DIM_W'(s.quot) * DIM_W'(OUT_WIDTH);
        s.rem = COL_RW'(s.size - prod);
        return s;
    endfunction

    function automatic t_row_step make_row(input logic [11:0] v);
        t_row_step s;
        logic [DIM_W-1:0] prod;
        s.size = clamp_dim(v, OUT_HEIGHT);
        s.quot = '0;
        for (int k = 1; k <= MAX_SOURCE_DIM / OUT_HEIGHT; k++) begin
            if (s.size >= DIM_W'(k * OUT_HEIGHT)) begin
                s.quot = RQ_W'(k);
            end
        end
        prod  = DIM_W'(s.quot) * DIM_W'(OUT_HEIGHT);
        s.rem = ROW_RW'(s.size - prod);
        return s;
    endfunction

    t_scale r_scale;
    t_scale n_scale;

    always_comb begin
        n_scale = r_scale;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  n_scale.col = make_col(i_cfg_data);
                CFG_SOURCE_HEIGHT: n_scale.row = make_row(i_cfg_data);
                default:           n_scale = r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale.col <= make_col(12'(SRC_W_RESET));
            r_scale.row <= make_row(12'(SRC_H_RESET));
        end else begin
            r_scale <= n_scale;
        end
    end

    assign o_scale = r_scale;

endmodule

>>> rtl/rngd_gray.sv
// RGB565 to 8-bit luma: bit-replicate channels, weighted sum, take the high byte.
module rngd_gray (
    input  logic [15:0] i_pixel,
    output logic [7:0]  o_gray
);
    import rngd_pkg::*;

    logic [7:0]  w_r8;
    logic [7:0]  w_g8;
    logic [7:0]  w_b8;
    logic [15:0] w_sum;

    assign w_r8  = {i_pixel[15:11], i_pixel[15:13]};
    assign w_g8  = {i_pixel[10:5],  i_pixel[10:9]};
    assign w_b8  = {i_pixel[4:0],   i_pixel[4:2]};
    assign w_sum = 16'(w_r8) * 16'(GRAY_R) + 16'(w_g8) * 16'(GRAY_G)
                 + 16'(w_b8) * 16'(GRAY_B);
    assign o_gray = w_sum[15:8];

endmodule

>>> rtl/rngd_pos.sv
// Source and output position counters with remainder-walk sample targets.
module rngd_pos (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_frame_start,
    input  rngd_pkg::t_scale i_scale,
    output rngd_pkg::t_pos   o_pos
);
    import rngd_pkg::*;

    logic [SRC_W-1:0]  r_src_col, n_src_col, e_src_col;
    logic [SRC_W-1:0]  r_src_row, n_src_row, e_src_row;
    logic [NCOL_W-1:0] r_ncol, n_ncol, e_ncol;
    logic [DIM_W-1:0]  r_col_tgt, n_col_tgt, e_col_tgt;
    logic [COL_RW-1:0] r_col_rem, n_col_rem, e_col_rem;
    logic [NROW_W-1:0] r_nrow, n_nrow, e_nrow;
    logic [DIM_W-1:0]  r_row_tgt, n_row_tgt, e_row_tgt;
    logic [ROW_RW-1:0] r_row_rem, n_row_rem, e_row_rem;

    logic              w_row_hit;
    logic              w_hit;
    logic              w_row_end;
    logic              w_frame_end;
    logic [COL_RW:0]   w_col_sum;
    logic              w_col_wrap;
    logic [ROW_RW:0]   w_row_sum;
    logic              w_row_wrap;

    always_comb begin
        // Frame start clears every counter before the pixel is looked at.
        e_src_col = i_frame_start ? '0 : r_src_col;
        e_src_row = i_frame_start ? '0 : r_src_row;
        e_ncol    = i_frame_start ? '0 : r_ncol;
        e_col_tgt = i_frame_start ? '0 : r_col_tgt;
        e_col_rem = i_frame_start ? '0 : r_col_rem;
        e_nrow    = i_frame_start ? '0 : r_nrow;
        e_row_tgt = i_frame_start ? '0 : r_row_tgt;
        e_row_rem = i_frame_start ? '0 : r_row_rem;

        w_row_hit = (DIM_W'(e_src_row) == e_row_tgt) && (e_nrow < NROW_W'(OUT_HEIGHT));
        w_hit     = w_row_hit && (DIM_W'(e_src_col) == e_col_tgt)
                 && (e_ncol < NCOL_W'(OUT_WIDTH));
        w_row_end   = (DIM_W'(e_src_col) + DIM_W'(1)) >= i_scale.col.size;
        w_frame_end = (DIM_W'(e_src_row) + DIM_W'(1)) >= i_scale.row.size;

        w_col_sum  = (COL_RW+1)'(e_col_rem) + (COL_RW+1)'(i_scale.col.rem);
        w_col_wrap = w_col_sum >= (COL_RW+1)'(OUT_WIDTH);
        w_row_sum  = (ROW_RW+1)'(e_row_rem) + (ROW_RW+1)'(i_scale.row.rem);
        w_row_wrap = w_row_sum >= (ROW_RW+1)'(OUT_HEIGHT);

        n_src_col = e_src_col;
        n_src_row = e_src_row;
        n_ncol    = e_ncol;
        n_col_tgt = e_col_tgt;
        n_col_rem = e_col_rem;
        n_nrow    = e_nrow;
        n_row_tgt = e_row_tgt;
        n_row_rem = e_row_rem;

        if (w_hit) begin
            n_ncol    = e_ncol + NCOL_W'(1);
            n_col_tgt = e_col_tgt + DIM_W'(i_scale.col.quot) + DIM_W'(w_col_wrap);
            n_col_rem = w_col_wrap ? COL_RW'(w_col_sum - (COL_RW+1)'(OUT_WIDTH))
                                   : COL_RW'(w_col_sum);
        end

        if (w_row_end) begin
            n_src_col = '0;
            n_ncol    = '0;
            n_col_tgt = '0;
            n_col_rem = '0;
            if (w_row_hit) begin
                n_nrow    = e_nrow + NROW_W'(1);
                n_row_tgt = e_row_tgt + DIM_W'(i_scale.row.quot) + DIM_W'(w_row_wrap);
                n_row_rem = w_row_wrap ? ROW_RW'(w_row_sum - (ROW_RW+1)'(OUT_HEIGHT))
                                       : ROW_RW'(w_row_sum);
            end
            if (w_frame_end) begin
                // Wrap to the top as if a new frame had started.
                n_src_row = '0;
                n_nrow    = '0;
                n_row_tgt = '0;
                n_row_rem = '0;
            end else begin
                n_src_row = e_src_row + SRC_W'(1);
            end
        end else begin
            n_src_col = e_src_col + SRC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_ncol    <= '0;
            r_col_tgt <= '0;
            r_col_rem <= '0;
            r_nrow    <= '0;
            r_row_tgt <= '0;
            r_row_rem <= '0;
        end else if (i_step) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_ncol    <= n_ncol;
            r_col_tgt <= n_col_tgt;
            r_col_rem <= n_col_rem;
            r_nrow    <= n_nrow;
            r_row_tgt <= n_row_tgt;
            r_row_rem <= n_row_rem;
        end
    end

    assign o_pos.hit    = w_hit;
    assign o_pos.column = OCOL_W'(e_ncol);
    assign o_pos.row    = OROW_W'(e_nrow);
    assign o_pos.last   = (e_ncol == NCOL_W'(OUT_WIDTH - 1))
                       && (e_nrow == NROW_W'(OUT_HEIGHT - 1));

endmodule

>>> bench/rgb565_nearest_downscale_gray_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the RGB565 nearest-neighbor gray downscaler.
module rgb565_nearest_downscale_gray_test;
    import rngd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_PRINTED     = 50;

    // Tracks source/output positions and queues the gray pixels the block must emit.
    class downscale_tracker;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        int unsigned src_col;
        int unsigned src_row;
        int unsigned next_col;
        int unsigned col_tgt;
        int unsigned col_rem;
        int unsigned next_row;
        int unsigned row_tgt;
        int unsigned row_rem;
        t_gray_out   pending_gray[$];
        int          errors;

        function new();
            width_reg  = 12'(SRC_W_RESET);
            height_reg = 12'(SRC_H_RESET);
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_columns();
            src_col  = 0;
            next_col = 0;
            col_tgt  = 0;
            col_rem  = 0;
        endfunction

        function void clear_frame();
            clear_columns();
            src_row  = 0;
            next_row = 0;
            row_tgt  = 0;
            row_rem  = 0;
        endfunction

        function int unsigned clamp_dim(logic [11:0] v, int unsigned lo);
            if (v < lo) return lo;
            if (v > MAX_SOURCE_DIM) return MAX_SOURCE_DIM;
            return v;
        endfunction

        function logic [7:0] luma(logic [15:0] px);
            logic [7:0]  r8;
            logic [7:0]  g8;
            logic [7:0]  b8;
            int unsigned sum;
            r8  = {px[15:11], px[15:13]};
            g8  = {px[10:5], px[10:9]};
            b8  = {px[4:0], px[4:2]};
            sum = GRAY_R * r8 + GRAY_G * g8 + GRAY_B * b8;
            return sum[15:8];
        endfunction

        // Step a sample position by size/outs without carrying a fraction.
        function void advance(inout int unsigned tgt, inout int unsigned rem,
                              input int unsigned size, input int unsigned outs);
            tgt += size / outs;
            rem += size % outs;
            if (rem >= outs) begin
                rem -= outs;
                tgt += 1;
            end
        endfunction

        function void set_register(t_cfg_idx idx, logic [11:0] value);
            if (idx == CFG_SOURCE_WIDTH) width_reg = value;
            else height_reg = value;
        endfunction

        function void note_pixel(t_pix_in px);
            int unsigned w;
            int unsigned h;
            bit          row_hit;
            t_gray_out   res;
            w = clamp_dim(width_reg, OUT_WIDTH);
            h = clamp_dim(height_reg, OUT_HEIGHT);
            if (px.frame_start) clear_frame();
            row_hit = (src_row == row_tgt) && (next_row < OUT_HEIGHT);
            if (row_hit && src_col == col_tgt && next_col < OUT_WIDTH) begin
                res.gray_value = luma(px.pixel_rgb565);
                res.out_column = next_col[OCOL_W-1:0];
                res.out_row    = next_row[OROW_W-1:0];
                res.frame_done = (next_col == OUT_WIDTH - 1) && (next_row == OUT_HEIGHT - 1);
                pending_gray.push_back(res);
                next_col += 1;
                advance(col_tgt, col_rem, w, OUT_WIDTH);
            end
            if (src_col + 1 >= w) begin
                clear_columns();
                if (row_hit) begin
                    next_row += 1;
                    advance(row_tgt, row_rem, h, OUT_HEIGHT);
                end
                // Wrap to row 0 when the frame runs past its last row.
                if (src_row + 1 >= h) clear_frame();
                else src_row += 1;
            end else begin
                src_col += 1;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_gray(t_gray_out got);
            t_gray_out want;
            if (pending_gray.size() == 0) begin
                report_mismatch($sformatf("unexpected gray transfer %h", got));
                return;
            end
            want = pending_gray.pop_front();
            if (got.gray_value !== want.gray_value)
                report_mismatch($sformatf("gray_value got %0d want %0d",
                                          got.gray_value, want.gray_value));
            if (got.out_column !== want.out_column)
                report_mismatch($sformatf("out_column got %0d want %0d",
                                          got.out_column, want.out_column));
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("out_row got %0d want %0d",
                                          got.out_row, want.out_row));
            if (got.frame_done !== want.frame_done)
                report_mismatch($sformatf("frame_done got %0d want %0d",
                                          got.frame_done, want.frame_done));
        endtask

        function int pending();
            return pending_gray.size();
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    t_cfg_idx    i_cfg_idx    = CFG_SOURCE_WIDTH;
    logic [11:0] i_cfg_data   = '0;
    logic        i_pix_valid  = 1'b0;
    logic        o_pix_ready;
    t_pix_in     i_pix        = '0;
    logic        o_gray_valid;
    logic        i_gray_ready = 1'b0;
    t_gray_out   o_gray;

    downscale_tracker board;
    bit fast_send    = 1'b0;
    bit fast_recv    = 1'b0;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    rgb565_nearest_downscale_gray uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_pix_valid),
        .o_pix_ready  (o_pix_ready),
        .i_pix        (i_pix),
        .o_gray_valid (o_gray_valid),
        .i_gray_ready (i_gray_ready),
        .o_gray       (o_gray)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_pix_valid && o_pix_ready) || (o_gray_valid && i_gray_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** rgb565_nearest_downscale_gray: FAILED **");
                $finish;
            end
        end
    end

    // Result side: random gaps, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = fast_recv ? 0 : $urandom_range(0, 14);
            if (hold_off_req) begin
                gap          = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (gap > 0) begin
                i_gray_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_gray_ready = 1'b1;
            @(posedge i_clk);
            while (!o_gray_valid) @(posedge i_clk);
            board.check_gray(o_gray);
            @(negedge i_clk);
        end
    end

    task automatic send_pixel(input t_pix_in px);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_pix_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pix       = px;
        i_pix_valid = 1'b1;
        @(posedge i_clk);
        while (!o_pix_ready) @(posedge i_clk);
        board.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_pix_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // Drain, then let pixels that make no result leave the pipeline.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [11:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic set_size(input logic [11:0] w, input logic [11:0] h);
        write_reg(CFG_SOURCE_WIDTH, w);
        write_reg(CFG_SOURCE_HEIGHT, h);
    endtask

    task automatic run_phase(input int count, input bit open_frame, input int start_permille);
        t_pix_in px;
        int      pause_at;
        pause_at = $urandom_range(0, 1) ? $urandom_range(1, count - 1) : -1;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) wait_results();
            px.pixel_rgb565 = $urandom;
            px.frame_start  = (k == 0) ? open_frame : ($urandom_range(0, 999) < start_permille);
            send_pixel(px);
        end
        i_pix_valid = 1'b0;
    endtask

    // Channel extremes and frame marks, back to back and mid-row.
    task automatic directed_pixels();
        logic [15:0] corners [14] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                                      16'h0821, 16'h8410, 16'h7BEF, 16'hAAAA, 16'h5555,
                                      16'hF81F, 16'h07FF, 16'hFFE0, 16'h0001};
        t_pix_in px;
        for (int k = 0; k < 14; k++) begin
            px.pixel_rgb565 = corners[k];
            px.frame_start  = (k == 0 || k == 6 || k == 7);
            send_pixel(px);
        end
        i_pix_valid = 1'b0;
    endtask

    initial begin
        board = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_pixels();
        settle();

        set_size(12'd0, 12'd0);
        run_phase(100, 1'b1, 5);
        settle();
        set_size(12'd321, 12'd241);
        run_phase(60, 1'b1, 5);
        settle();
        set_size(12'hFFF, 12'hFFF);
        run_phase(50, 1'b1, 0);
        settle();
        set_size(12'd2048, 12'd2048);
        run_phase(100, 1'b0, 0);
        settle();
        set_size(12'd2047, 12'd300);
        run_phase(300, 1'b0, 0);
        settle();

        // Shrink the width mid-row; stall the result side while pixels keep coming.
        set_size(12'd320, 12'd240);
        fast_send    = 1'b1;
        hold_off_req = 1'b1;
        run_phase(120, 1'b0, 0);
        fast_send    = 1'b0;
        settle();

        // Both sides at full rate.
        set_size(12'd640, 12'd480);
        fast_send = 1'b1;
        fast_recv = 1'b1;
        run_phase(100, 1'b1, 5);
        fast_send = 1'b0;
        fast_recv = 1'b0;
        settle();
        set_size(12'd1000, 12'd250);
        run_phase(100, 1'b1, 10);
        settle();
        set_size(12'd100, 12'd3000);
        run_phase(100, 1'b1, 5);
        settle();
        repeat (2) begin
            set_size(12'($urandom_range(OUT_WIDTH, MAX_SOURCE_DIM)),
                     12'($urandom_range(OUT_HEIGHT, MAX_SOURCE_DIM)));
            run_phase(50, 1'($urandom_range(0, 1)), 10);
            settle();
        end

        if (board.errors == 0) begin
            $display("** rgb565_nearest_downscale_gray: PASSED **");
        end else begin
            $display("** rgb565_nearest_downscale_gray: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rngd_pkg.sv
rtl/rngd_cfg.sv
rtl/rngd_gray.sv
rtl/rngd_pos.sv
rtl/rgb565_nearest_downscale_gray.sv
bench/rgb565_nearest_downscale_gray_test.sv
